FILE: sv/pes_pkg.sv
// Package for the pattern endian swapper: widths, configuration register
// codes, the configuration bundle and the word issue bundle.
// No dependencies; every other file of the block imports it.
package pes_pkg;

    localparam int BYTE_W     = 8;
    localparam int SIZE_W     = 4;
    localparam int COUNT_W    = 16;
    localparam int GROUP_W    = 2;
    localparam int NUM_GROUPS = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Group index value that lies past the last group.
    localparam logic [GROUP_W-1:0] GROUP_END = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_COUNT_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_COUNT_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE_C  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_COUNT_C = 3'd6;

    // Current register contents, as seen by the controller.
    typedef struct packed {
        logic                                  swap_enable;
        logic [NUM_GROUPS-1:0][SIZE_W-1:0]     elem_size;
        logic [NUM_GROUPS-1:0][COUNT_W-1:0]    elem_count;
    } cfg_t;

    // One output word handed from the controller to the output stage.
    // When from_mem is set the byte comes from the element store read
    // issued in the same cycle; otherwise data carries it.
    typedef struct packed {
        logic              valid;
        logic              from_mem;
        logic              last;
        logic [BYTE_W-1:0] data;
    } issue_t;

endpackage

FILE: sv/pes_if.sv
// Stream interfaces of the pattern endian swapper: the raw record bytes
// and the converted bytes. Depends on pes_pkg for the byte width.
interface pes_in_if;
    import pes_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              record_start;

    modport source (output valid, output data_byte, output record_start, input ready);
    modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface pes_out_if;
    import pes_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: sv/pes_cfg.sv
// Configuration register file of the pattern endian swapper.
// Depends on pes_pkg for the register codes and the cfg_t bundle.
module pes_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [pes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pes_pkg::CFG_DATA_W-1:0] cfg_data,
    output pes_pkg::cfg_t            cfg
);
    import pes_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg             <= '0;
            cfg_reg.swap_enable <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SWAP_ENABLE:  cfg_reg.swap_enable   <= cfg_data[0];
                REG_ELEM_SIZE_A:  cfg_reg.elem_size[0]  <= cfg_data[SIZE_W-1:0];
                REG_ELEM_COUNT_A: cfg_reg.elem_count[0] <= cfg_data[COUNT_W-1:0];
                REG_ELEM_SIZE_B:  cfg_reg.elem_size[1]  <= cfg_data[SIZE_W-1:0];
                REG_ELEM_COUNT_B: cfg_reg.elem_count[1] <= cfg_data[COUNT_W-1:0];
                REG_ELEM_SIZE_C:  cfg_reg.elem_size[2]  <= cfg_data[SIZE_W-1:0];
                REG_ELEM_COUNT_C: cfg_reg.elem_count[2] <= cfg_data[COUNT_W-1:0];
                default:          cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/pes_mem.sv
// Element store of the pattern endian swapper: one write port and one
// read port with registered read data. Depends on pes_pkg for the width.
module pes_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [pes_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [pes_pkg::BYTE_W-1:0] rdata
);
    import pes_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/pes_out.sv
// Output stage of the pattern endian swapper: a pending stage that meets
// the element store read data, then the output register.
// Depends on pes_pkg and the pes_out_if interface.
module pes_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pes_pkg::issue_t            issue,
    input  logic [pes_pkg::BYTE_W-1:0] mem_rdata,
    output logic                       can_issue,
    pes_out_if.source                  converted
);
    import pes_pkg::*;

    logic              pend_valid_reg;
    logic              pend_mem_reg;
    logic              pend_last_reg;
    logic [BYTE_W-1:0] pend_byte_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [BYTE_W-1:0] out_byte_reg;

    logic              out_free;
    logic              pend_move;
    logic [BYTE_W-1:0] pend_data;

    // The pending word moves on whenever the output register frees up.
    assign out_free  = !out_valid_reg || converted.ready;
    assign pend_move = pend_valid_reg && out_free;
    assign can_issue = !pend_valid_reg || out_free;
    assign pend_data = pend_mem_reg ? mem_rdata : pend_byte_reg;

    // Pending stage and output register valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (issue.valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (converted.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            pend_mem_reg  <= issue.from_mem;
            pend_last_reg <= issue.last;
            pend_byte_reg <= issue.data;
        end
        if (pend_move)
        begin
            out_byte_reg <= pend_data;
            out_last_reg <= pend_last_reg;
        end
    end

    assign converted.valid    = out_valid_reg;
    assign converted.out_byte = out_byte_reg;
    assign converted.run_last = out_last_reg;

endmodule

FILE: sv/pes_ctrl.sv
// Controller of the pattern endian swapper: pattern tracking, element
// store writes and the read sequencing for flushes and reversed releases.
// Depends on pes_pkg and the pes_in_if interface.
module pes_ctrl #(
    parameter int MAX_ELEMENT_BYTES = 8,
    parameter int ADDR_W            = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pes_pkg::cfg_t              cfg,
    pes_in_if.sink                     record,
    input  logic                       can_issue,
    output pes_pkg::issue_t            issue,
    output logic                       mem_we,
    output logic [ADDR_W-1:0]          mem_waddr,
    output logic [pes_pkg::BYTE_W-1:0] mem_wdata,
    output logic                       mem_re,
    output logic [ADDR_W-1:0]          mem_raddr
);
    import pes_pkg::*;

    localparam int CMP_W        = (ADDR_W > SIZE_W) ? ADDR_W + 1 : SIZE_W + 1;
    localparam int SETTLE_STEPS = NUM_GROUPS + 1;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_ELEMENT_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_STORE,
        ST_RELEASE
    } state_t;

    typedef enum logic [1:0] {
        ACT_PASS,
        ACT_HOLD,
        ACT_RELEASE
    } act_t;

    state_t              state_reg;
    act_t                act_reg;
    logic [GROUP_W-1:0]  gi_reg;
    logic [COUNT_W-1:0]  rc_reg;
    logic [ADDR_W-1:0]   bp_reg;
    logic                pd_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [ADDR_W-1:0]   wr_pos_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   flush_last_reg;

    logic [GROUP_W-1:0]  s_gi;
    logic [COUNT_W-1:0]  s_rc;
    logic [ADDR_W-1:0]   s_bp;
    logic                s_pd;
    logic [GROUP_W-1:0]  gi_next;
    logic [COUNT_W-1:0]  rc_next;
    logic [ADDR_W-1:0]   bp_next;
    logic                pd_next;
    logic                settle_stop;
    logic [CMP_W-1:0]    e_size;
    logic [CMP_W-1:0]    pos1;
    act_t                act_next;
    logic                accept;

    function automatic logic [SIZE_W-1:0] grp_size(cfg_t c, logic [GROUP_W-1:0] g);
        logic [SIZE_W-1:0] s;
        case (g)
            2'd0:    s = c.elem_size[0];
            2'd1:    s = c.elem_size[1];
            2'd2:    s = c.elem_size[2];
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [COUNT_W-1:0] grp_count(cfg_t c, logic [GROUP_W-1:0] g);
        logic [COUNT_W-1:0] n;
        case (g)
            2'd0:    n = c.elem_count[0];
            2'd1:    n = c.elem_count[1];
            2'd2:    n = c.elem_count[2];
            default: n = '0;
        endcase
        return n;
    endfunction

    // Element size clamped to the store depth.
    function automatic logic [CMP_W-1:0] eff_size(cfg_t c, logic [GROUP_W-1:0] g);
        logic [CMP_W-1:0] s;
        s = CMP_W'(grp_size(c, g));
        return (s > MAX_C) ? MAX_C : s;
    endfunction

    assign record.ready = (state_reg == ST_IDLE);
    assign accept       = record.valid && record.ready;

    // Decision for the offered byte. A record start clears the pattern
    // state first; a new group is chosen only when nothing is held.
    always_comb
    begin
        s_gi = record.record_start ? '0   : gi_reg;
        s_rc = record.record_start ? '0   : rc_reg;
        s_bp = record.record_start ? '0   : bp_reg;
        s_pd = record.record_start ? 1'b0 : pd_reg;

        gi_next     = s_gi;
        rc_next     = s_rc;
        pd_next     = s_pd;
        settle_stop = 1'b0;
        if (cfg.swap_enable && s_bp == '0)
        begin
            for (int k = 0; k < SETTLE_STEPS; k++)
            begin
                if (!pd_next && !settle_stop)
                begin
                    if (gi_next == GROUP_END || grp_size(cfg, gi_next) == '0)
                    begin
                        pd_next = 1'b1;
                    end
                    else if (rc_next >= grp_count(cfg, gi_next))
                    begin
                        gi_next = gi_next + GROUP_W'(1);
                        rc_next = '0;
                        if (gi_next == GROUP_END)
                        begin
                            pd_next = 1'b1;
                        end
                    end
                    else
                    begin
                        settle_stop = 1'b1;
                    end
                end
            end
        end

        e_size   = eff_size(cfg, gi_next);
        pos1     = CMP_W'(s_bp) + CMP_W'(1);
        act_next = ACT_PASS;
        bp_next  = s_bp;
        if (cfg.swap_enable && !(pd_next && s_bp == '0))
        begin
            if (pos1 >= e_size || pos1 >= MAX_C)
            begin
                act_next = ACT_RELEASE;
                bp_next  = '0;
                rc_next  = rc_next + COUNT_W'(1);
            end
            else
            begin
                act_next = ACT_HOLD;
                bp_next  = ADDR_W'(pos1);
            end
        end
    end

    // Sequencer: accept, flush held bytes in arrival order, store or pass
    // the new byte, then release a finished element in reverse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            act_reg        <= ACT_PASS;
            gi_reg         <= '0;
            rc_reg         <= '0;
            bp_reg         <= '0;
            pd_reg         <= 1'b1;
            byte_reg       <= '0;
            wr_pos_reg     <= '0;
            addr_reg       <= '0;
            flush_last_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        gi_reg         <= gi_next;
                        rc_reg         <= rc_next;
                        bp_reg         <= bp_next;
                        pd_reg         <= pd_next;
                        act_reg        <= act_next;
                        byte_reg       <= record.data_byte;
                        wr_pos_reg     <= s_bp;
                        addr_reg       <= '0;
                        flush_last_reg <= bp_reg - ADDR_W'(1);
                        if (record.record_start && bp_reg != '0)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            state_reg <= ST_STORE;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (can_issue)
                    begin
                        if (addr_reg == flush_last_reg)
                        begin
                            state_reg <= ST_STORE;
                        end
                        else
                        begin
                            addr_reg <= addr_reg + ADDR_W'(1);
                        end
                    end
                end
                ST_STORE:
                begin
                    if (act_reg == ACT_PASS)
                    begin
                        if (can_issue)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (act_reg == ACT_RELEASE)
                    begin
                        addr_reg  <= wr_pos_reg;
                        state_reg <= ST_RELEASE;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RELEASE:
                begin
                    if (can_issue)
                    begin
                        if (addr_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            addr_reg <= addr_reg - ADDR_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Word issue toward the output stage and element store access.
    always_comb
    begin
        issue.valid    = 1'b0;
        issue.from_mem = 1'b1;
        issue.last     = 1'b0;
        issue.data     = byte_reg;
        case (state_reg)
            ST_FLUSH:
            begin
                issue.valid = can_issue;
                issue.last  = (addr_reg == flush_last_reg) && (act_reg == ACT_HOLD);
            end
            ST_STORE:
            begin
                issue.valid    = can_issue && (act_reg == ACT_PASS);
                issue.from_mem = 1'b0;
                issue.last     = 1'b1;
            end
            ST_RELEASE:
            begin
                issue.valid = can_issue;
                issue.last  = (addr_reg == '0);
            end
            default:
            begin
                issue.valid = 1'b0;
            end
        endcase
    end

    assign mem_we    = (state_reg == ST_STORE) && (act_reg != ACT_PASS);
    assign mem_waddr = wr_pos_reg;
    assign mem_wdata = byte_reg;
    assign mem_re    = issue.valid && issue.from_mem;
    assign mem_raddr = addr_reg;

endmodule

FILE: sv/pattern_endian_swapper.sv
// Pattern endian swapper, top level.
// Depends on pes_pkg, pes_if, pes_cfg, pes_mem, pes_out and pes_ctrl.
// Usage: bytes of a record enter on the record channel, one word per
// handshake, with record_start set on the first byte of each record.
// Converted bytes leave on the converted channel; run_last marks the final
// word caused by one input byte. Registers are written through cfg_write,
// cfg_index and cfg_data, by the user only while the block is idle; the
// block does not enforce it. Indexes past six are ignored. Up to three
// groups of (element size, count) describe a record.
//
// Flow: a byte that passes through or completes an element is accepted,
// decided and stored, then the element is read back in reverse, each word
// going through the pending stage and the output register. A byte that
// is only held is accepted, then stored. A record start with held bytes
// first flushes them in arrival order. The element store read port sets
// the release rate of one word per cycle unless the receiver stalls.
// Reset clears the pattern state and leaves pass-through active until the
// first record start; the element store itself is not cleared. When the
// receiver stalls, the output register and one pending word hold, and the
// controller stops issuing reads until the pending stage frees.
module pattern_endian_swapper #(
    parameter int MAX_ELEMENT_BYTES = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [pes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pes_pkg::CFG_DATA_W-1:0] cfg_data,
    pes_in_if.sink                       record,
    pes_out_if.source                    converted
);
    import pes_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ELEMENT_BYTES);

    cfg_t              cfg;
    issue_t            issue;
    logic              can_issue;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    // Configuration registers.
    pes_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pattern tracking and read sequencing.
    pes_ctrl #(
        .MAX_ELEMENT_BYTES (MAX_ELEMENT_BYTES),
        .ADDR_W            (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .record    (record),
        .can_issue (can_issue),
        .issue     (issue),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr)
    );

    // Element store.
    pes_mem #(
        .DEPTH  (MAX_ELEMENT_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Pending stage and output register.
    pes_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .mem_rdata (mem_rdata),
        .can_issue (can_issue),
        .converted (converted)
    );

endmodule
